### sv/synth_voice_allocator_core_assert.svh
// assertion macros shared by the checker file
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SVALLOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SVALLOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/svalloc_pkg.sv
package svalloc_pkg;

  // field widths
  localparam int FUNC_W    = 3;
  localparam int FREQ_W    = 21;
  localparam int VEL_W     = 8;
  localparam int VOICE_W   = 3;
  localparam int ACT_W     = 2;
  localparam int CNT_OUT_W = 4;
  localparam int AGE_W     = 32;
  localparam int TOL_W     = 8;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // defaults and limits
  localparam int NUM_VOICES_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [ACT_W-1:0]  act_t;

  // command codes
  localparam func_t FUNC_NOTE_ON    = 3'd0;
  localparam func_t FUNC_NOTE_OFF   = 3'd1;
  localparam func_t FUNC_ALL_OFF    = 3'd2;
  localparam func_t FUNC_VOICE_DONE = 3'd3;
  localparam func_t FUNC_CLEAR      = 3'd4;

  // result action codes
  localparam act_t ACT_ACK     = 2'd0;
  localparam act_t ACT_START   = 2'd1;
  localparam act_t ACT_RELEASE = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_MATCH_TOL = 1'b0;

endpackage

### sv/synth_voice_allocator_core.sv
// channel   direction  transfer when            payload
// in_       input      in_valid & !in_stall     func, note_freq, note_velocity, done_voice
// out_      output     out_valid & !out_stall   action, voice, start_freq, start_velocity,
//                                               stolen, active_count, last
// cfg       apb        psel & penable & pwrite  match_tolerance at byte address 0
//
// one item at a time; each voice is read, then checked, through the single
// read port of the age/frequency RAM and one shared subtract/compare unit
// note_on stops at the lowest idle voice; note_off/all_off scan until MAX_RESULTS matches
// or the last voice; any state that loads the output register waits on out_stall
// the output register lets a new item enter while the last result still waits
// synchronous active-low reset, no clearing pass: the active bits gate every RAM read
module synth_voice_allocator_core #(
  parameter int NUM_VOICES = svalloc_pkg::NUM_VOICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [svalloc_pkg::FUNC_W-1:0]     in_func,
  input  logic [svalloc_pkg::FREQ_W-1:0]     in_note_freq,
  input  logic [svalloc_pkg::VEL_W-1:0]      in_note_velocity,
  input  logic [svalloc_pkg::VOICE_W-1:0]    in_done_voice,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [svalloc_pkg::ACT_W-1:0]      out_action,
  output logic [svalloc_pkg::VOICE_W-1:0]    out_voice,
  output logic [svalloc_pkg::FREQ_W-1:0]     out_start_freq,
  output logic [svalloc_pkg::VEL_W-1:0]      out_start_velocity,
  output logic                               out_stolen,
  output logic [svalloc_pkg::CNT_OUT_W-1:0]  out_active_count,
  output logic                               out_last,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [svalloc_pkg::ADDR_W-1:0]     paddr,
  input  logic [svalloc_pkg::DATA_W-1:0]     pwdata,
  output logic [svalloc_pkg::DATA_W-1:0]     prdata,
  output logic                               pready
);

  import svalloc_pkg::*;

  localparam int IDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W   = $clog2(NUM_VOICES + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int ENTRY_W = AGE_W + FREQ_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_START,
    S_REL_END,
    S_SIMPLE
  } state_t;

  state_t               state_r;
  logic [TOL_W-1:0]     tol_r;
  logic [NUM_VOICES-1:0] active_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [AGE_W-1:0]     stamp_r;

  // latched item
  func_t                func_r;
  logic [FREQ_W-1:0]    freq_r;
  logic [VEL_W-1:0]     vel_r;
  logic [VOICE_W-1:0]   dv_r;

  // scan bookkeeping
  logic [IDX_W-1:0]     idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idle_idx_r;
  logic [AGE_W-1:0]     best_age_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 pend_r;
  logic [IDX_W-1:0]     pend_voice_r;
  logic [RES_W-1:0]     nres_r;

  // output register
  logic                 out_valid_r;
  act_t                 out_action_r;
  logic [VOICE_W-1:0]   out_voice_r;
  logic [FREQ_W-1:0]    out_freq_r;
  logic [VEL_W-1:0]     out_vel_r;
  logic                 out_stolen_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_last_r;

  // ram interface
  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  logic [ENTRY_W-1:0]   ram_wr_data;
  logic                 ram_rd_en;
  logic [ENTRY_W-1:0]   ram_rd_data;

  // datapath
  logic                 out_free;
  logic                 out_load;
  logic                 idx_last;
  logic [AGE_W-1:0]     rd_age;
  logic [FREQ_W-1:0]    rd_freq;
  logic [FREQ_W-1:0]    freq_diff;
  logic                 rel_match;
  logic [RES_W-1:0]     nres_nxt;
  logic [AGE_W-1:0]     stamp_nxt;
  logic [IDX_W-1:0]     dv_idx;
  logic                 dv_hit;
  logic [CNT_W-1:0]     simple_cnt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATCH_TOL) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MATCH_TOL) ? DATA_W'(tol_r) : '0;

  // age and frequency of each voice
  svalloc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VOICES)
  ) u_voice_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  assign ram_rd_en   = (state_r == S_SCAN_RD);
  assign ram_wr_en   = (state_r == S_START) && out_free;
  assign ram_wr_addr = found_r ? idle_idx_r : best_idx_r;
  assign ram_wr_data = {stamp_nxt, freq_r};

  // shared compare unit for the scan
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_last  = (idx_r == IDX_W'(NUM_VOICES - 1));
  assign rd_age    = ram_rd_data[ENTRY_W-1:FREQ_W];
  assign rd_freq   = ram_rd_data[FREQ_W-1:0];
  assign freq_diff = (rd_freq > freq_r) ? (rd_freq - freq_r) : (freq_r - rd_freq);
  assign rel_match = active_r[idx_r] &&
                     (func_r == FUNC_ALL_OFF || freq_diff < FREQ_W'(tol_r));
  assign nres_nxt  = nres_r + RES_W'(1);

  // the output register takes a new result this cycle
  assign out_load = out_free &&
                    ((state_r == S_START) || (state_r == S_REL_END) ||
                     (state_r == S_SIMPLE) ||
                     (state_r == S_SCAN_CHK && func_r != FUNC_NOTE_ON && rel_match && pend_r));

  // saturating age stamp
  assign stamp_nxt = (stamp_r == '1) ? stamp_r : stamp_r + AGE_W'(1);

  // voice_done target
  assign dv_idx = IDX_W'(dv_r);
  assign dv_hit = (32'(dv_r) < NUM_VOICES) && active_r[dv_idx];

  // active count after a voice_done or clear
  assign simple_cnt = (func_r == FUNC_CLEAR) ? '0 :
                      (func_r == FUNC_VOICE_DONE && dv_hit) ? cnt_r - CNT_W'(1) : cnt_r;

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      cnt_r       <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      nres_r      <= '0;
      idx_r       <= '0;
    end else begin
      // new result loaded, or the waiting one taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            freq_r  <= in_note_freq;
            vel_r   <= in_note_velocity;
            dv_r    <= in_done_voice;
            idx_r   <= '0;
            found_r <= 1'b0;
            pend_r  <= 1'b0;
            nres_r  <= '0;
            unique case (in_func)
              FUNC_NOTE_ON, FUNC_NOTE_OFF, FUNC_ALL_OFF: state_r <= S_SCAN_RD;
              default:                                   state_r <= S_SIMPLE;
            endcase
          end
        end

        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end

        S_SCAN_CHK: begin
          if (func_r == FUNC_NOTE_ON) begin
            // lowest idle voice wins, else track the oldest stamp
            if (!active_r[idx_r]) begin
              found_r    <= 1'b1;
              idle_idx_r <= idx_r;
              state_r    <= S_START;
            end else begin
              if (idx_r == '0 || rd_age < best_age_r) begin
                best_age_r <= rd_age;
                best_idx_r <= idx_r;
              end
              if (idx_last) begin
                state_r <= S_START;
              end else begin
                idx_r   <= idx_r + IDX_W'(1);
                state_r <= S_SCAN_RD;
              end
            end
          end else if (!(rel_match && pend_r && !out_free)) begin
            // a new match flushes the held release, which is not the last
            if (rel_match) begin
              if (pend_r) begin
                out_action_r <= ACT_RELEASE;
                out_voice_r  <= VOICE_W'(pend_voice_r);
                out_freq_r   <= '0;
                out_vel_r    <= '0;
                out_stolen_r <= 1'b0;
                out_cnt_r    <= CNT_OUT_W'(cnt_r);
                out_last_r   <= 1'b0;
              end
              pend_r       <= 1'b1;
              pend_voice_r <= idx_r;
              nres_r       <= nres_nxt;
            end
            if ((rel_match && nres_nxt == RES_W'(MAX_RESULTS)) || idx_last) begin
              state_r <= S_REL_END;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_SCAN_RD;
            end
          end
        end

        S_START: begin
          if (out_free) begin
            stamp_r                  <= stamp_nxt;
            active_r[ram_wr_addr]    <= 1'b1;
            if (found_r) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            out_action_r <= ACT_START;
            out_voice_r  <= VOICE_W'(ram_wr_addr);
            out_freq_r   <= freq_r;
            out_vel_r    <= vel_r;
            out_stolen_r <= !found_r;
            out_cnt_r    <= found_r ? CNT_OUT_W'(cnt_r + CNT_W'(1)) : CNT_OUT_W'(cnt_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        S_REL_END: begin
          // held release, or an acknowledge when nothing matched
          if (out_free) begin
            out_action_r <= pend_r ? ACT_RELEASE : ACT_ACK;
            out_voice_r  <= pend_r ? VOICE_W'(pend_voice_r) : '0;
            out_freq_r   <= '0;
            out_vel_r    <= '0;
            out_stolen_r <= 1'b0;
            out_cnt_r    <= CNT_OUT_W'(cnt_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        S_SIMPLE: begin
          if (out_free) begin
            out_action_r <= ACT_ACK;
            out_voice_r  <= (func_r == FUNC_VOICE_DONE) ? dv_r : '0;
            out_freq_r   <= '0;
            out_vel_r    <= '0;
            out_stolen_r <= 1'b0;
            out_cnt_r    <= CNT_OUT_W'(simple_cnt);
            out_last_r   <= 1'b1;
            cnt_r        <= simple_cnt;
            unique case (func_r)
              FUNC_VOICE_DONE: begin
                if (dv_hit) begin
                  active_r[dv_idx] <= 1'b0;
                end
              end
              FUNC_CLEAR: begin
                active_r <= '0;
                stamp_r  <= '0;
              end
              default: begin
              end
            endcase
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_voice          = out_voice_r;
  assign out_start_freq     = out_freq_r;
  assign out_start_velocity = out_vel_r;
  assign out_stolen         = out_stolen_r;
  assign out_active_count   = out_cnt_r;
  assign out_last           = out_last_r;

endmodule

### sv/svalloc_ram.sv
module svalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/svalloc_checker.sv
`include "synth_voice_allocator_core_assert.svh"

module svalloc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [svalloc_pkg::ACT_W-1:0]      out_action,
  input logic [svalloc_pkg::VOICE_W-1:0]    out_voice,
  input logic [svalloc_pkg::FREQ_W-1:0]     out_start_freq,
  input logic [svalloc_pkg::VEL_W-1:0]      out_start_velocity,
  input logic                               out_stolen,
  input logic [svalloc_pkg::CNT_OUT_W-1:0]  out_active_count,
  input logic                               out_last
);

  import svalloc_pkg::*;

  // a stalled result holds
  `SVALLOC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_action) && $stable(out_voice) && $stable(out_start_freq) && $stable(out_start_velocity) && $stable(out_stolen) && $stable(out_active_count) && $stable(out_last), "stalled result changed")

  // one item in flight: an accepted transfer closes the input
  `SVALLOC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "input open right after a transfer")

  // a start is always the only result of its item
  `SVALLOC_ASSERT_NOW(a_start_last, clk, rst_n, out_valid && out_action == ACT_START, out_last, "start result not marked last")

  // only a start carries note data
  `SVALLOC_ASSERT_NOW(a_no_note_data, clk, rst_n, out_valid && out_action != ACT_START, out_start_freq == '0 && out_start_velocity == '0 && !out_stolen, "note data on a non-start result")

endmodule

bind synth_voice_allocator_core svalloc_checker u_svalloc_checker (.*);
